[hdl/ect_pkg.sv]
// Package for the expression character tokenizer.
// Types, token codes and character constants shared by all modules in hdl/.
// No dependencies.
`default_nettype none
package ect_pkg;

  typedef enum logic [3:0] {
    TK_NUMBER = 4'd0,
    TK_SPACE  = 4'd1,
    TK_PLUS   = 4'd2,
    TK_MINUS  = 4'd3,
    TK_STAR   = 4'd4,
    TK_SLASH  = 4'd5,
    TK_OPEN   = 4'd6,
    TK_CLOSE  = 4'd7,
    TK_EOL    = 4'd8,
    TK_BAD    = 4'd9
  } tok_kind_e;

  typedef enum logic [1:0] {
    RUN_NONE  = 2'd0,
    RUN_DIGIT = 2'd1,
    RUN_BLANK = 2'd2
  } run_kind_e;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;

  localparam logic [34:0] ValueMax = 35'd2147483647;

  localparam int FifoDepth = 4;
  localparam int FifoAw    = 2;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    tok_kind_e   token_kind;
    logic [10:0] token_start;
    logic [10:0] token_length;
    logic [30:0] number_value;
    logic        run_last;
  } out_item_t;

  typedef struct packed {
    tok_kind_e   kind;
    logic [10:0] start;
    logic [10:0] length;
    logic [30:0] value;
  } tok_t;

  // slot 0: run closed by this byte, slot 1: operator/bad byte or run closed
  // by line end, slot 2: end of line
  typedef struct packed {
    logic [2:0]     vld;
    tok_t [2:0]     tok;
  } tok_group_t;

  function automatic tok_kind_e op_kind(input logic [7:0] ch);
    tok_kind_e k;
    case (ch)
      ChPlus:  k = TK_PLUS;
      ChMinus: k = TK_MINUS;
      ChStar:  k = TK_STAR;
      ChSlash: k = TK_SLASH;
      ChOpen:  k = TK_OPEN;
      ChClose: k = TK_CLOSE;
      default: k = TK_BAD;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

[hdl/ect_front.sv]
// Front end: classifies each byte, tracks the open run and builds the
// group of up to three tokens that the byte causes. Depends on ect_pkg.
`default_nettype none
module ect_front #(
  parameter int MAX_LINE_LEN = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire ect_pkg::in_item_t  item_i,
  output ect_pkg::tok_group_t     grp_o,
  output logic                    grp_vld_o
);
  import ect_pkg::*;

  localparam int PW = $clog2(MAX_LINE_LEN + 1);
  localparam logic [PW-1:0] LenMax = PW'(MAX_LINE_LEN);

  run_kind_e     run_kind_q, run_kind_d, cls;
  logic [PW-1:0] run_start_q, run_start_d;
  logic [PW-1:0] run_len_q, run_len_d;
  logic [PW-1:0] line_pos_q, line_pos_d;
  logic [30:0]   acc_q, acc_d;
  logic          ovf_q, ovf_d;
  logic          is_digit, is_blank;
  logic [34:0]   prod;
  tok_group_t    grp;

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
    return (v >= LenMax) ? LenMax : v + PW'(1);
  endfunction

  function automatic tok_t run_token(input run_kind_e k, input logic [PW-1:0] s,
                                     input logic [PW-1:0] l, input logic [30:0] a,
                                     input logic o);
    tok_t t;
    t.start  = 11'(s);
    t.length = 11'(l);
    t.value  = '0;
    if (k == RUN_DIGIT) begin
      if (o) begin
        t.kind = TK_BAD;
      end else begin
        t.kind  = TK_NUMBER;
        t.value = a;
      end
    end else begin
      t.kind = TK_SPACE;
    end
    return t;
  endfunction

  always_comb begin
    is_digit = item_i.char_in inside {[ChZero:ChNine]};
    is_blank = item_i.char_in inside {ChSpace, ChTab};
    cls = is_digit ? RUN_DIGIT : (is_blank ? RUN_BLANK : RUN_NONE);
    grp         = '0;
    prod        = '0;
    run_kind_d  = run_kind_q;
    run_start_d = run_start_q;
    run_len_d   = run_len_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    line_pos_d  = sat_inc(line_pos_q);

    if (run_kind_q != RUN_NONE && cls != run_kind_q) begin
      grp.vld[0] = 1'b1;
      grp.tok[0] = run_token(run_kind_q, run_start_q, run_len_q, acc_q, ovf_q);
      run_kind_d  = RUN_NONE;
      run_start_d = '0;
      run_len_d   = '0;
      acc_d       = '0;
      ovf_d       = 1'b0;
    end

    if (cls != RUN_NONE) begin
      if (run_kind_d == RUN_NONE) begin
        run_kind_d  = cls;
        run_start_d = line_pos_q;
        run_len_d   = '0;
        acc_d       = '0;
        ovf_d       = 1'b0;
      end
      run_len_d = sat_inc(run_len_d);
      if (is_digit && !ovf_d) begin
        prod = ({4'b0, acc_d} << 3) + ({4'b0, acc_d} << 1)
             + 35'(item_i.char_in - ChZero);
        if (prod > ValueMax) begin
          ovf_d = 1'b1;
          acc_d = '0;
        end else begin
          acc_d = prod[30:0];
        end
      end
    end else begin
      grp.vld[1]        = 1'b1;
      grp.tok[1].kind   = op_kind(item_i.char_in);
      grp.tok[1].start  = 11'(line_pos_q);
      grp.tok[1].length = 11'd1;
      grp.tok[1].value  = '0;
    end

    if (item_i.line_end) begin
      if (run_kind_d != RUN_NONE) begin
        grp.vld[1] = 1'b1;
        grp.tok[1] = run_token(run_kind_d, run_start_d, run_len_d, acc_d, ovf_d);
      end
      grp.vld[2]        = 1'b1;
      grp.tok[2].kind   = TK_EOL;
      grp.tok[2].start  = 11'(line_pos_d);
      grp.tok[2].length = '0;
      grp.tok[2].value  = '0;
      run_kind_d  = RUN_NONE;
      run_start_d = '0;
      run_len_d   = '0;
      acc_d       = '0;
      ovf_d       = 1'b0;
      line_pos_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_kind_q  <= RUN_NONE;
      run_start_q <= '0;
      run_len_q   <= '0;
      line_pos_q  <= '0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
    end else if (accept_i) begin
      run_kind_q  <= run_kind_d;
      run_start_q <= run_start_d;
      run_len_q   <= run_len_d;
      line_pos_q  <= line_pos_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
    end
  end

  assign grp_o     = grp;
  assign grp_vld_o = accept_i && (|grp.vld);

endmodule
`default_nettype wire

[hdl/ect_fifo.sv]
// Short queue of token groups between front and back end.
// Depends on ect_pkg.
`default_nettype none
module ect_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_i,
  input  wire ect_pkg::tok_group_t  wr_data_i,
  input  wire logic                 rd_i,
  output ect_pkg::tok_group_t       rd_data_o,
  output logic                      full_o,
  output logic                      not_empty_o
);
  import ect_pkg::*;

  tok_group_t        mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + FifoAw'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + FifoAw'(1);
      end
      cnt_q <= cnt_q + (FifoAw+1)'(wr_i) - (FifoAw+1)'(rd_i);
    end
  end

  assign rd_data_o   = mem_q[rd_ptr_q];
  assign full_o      = (cnt_q == (FifoAw+1)'(FifoDepth));
  assign not_empty_o = (cnt_q != '0);

endmodule
`default_nettype wire

[hdl/ect_back.sv]
// Back end: holds one token group and hands its tokens out one beat at a
// time, marking the last one. Depends on ect_pkg.
`default_nettype none
module ect_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ect_pkg::tok_group_t  grp_i,
  input  wire logic                 grp_avail_i,
  output logic                      grp_take_o,
  input  wire logic                 pop_i,
  output logic                      empty_o,
  output ect_pkg::out_item_t        item_o
);
  import ect_pkg::*;

  logic [2:0] vld_q, vld_d, sel, rem, vld_after;
  tok_t [2:0] tok_q;
  tok_t       cur;
  logic       load;

  always_comb begin
    sel = vld_q & ~(vld_q - 3'd1);
    rem = vld_q & ~sel;
    if (sel[0]) begin
      cur = tok_q[0];
    end else if (sel[1]) begin
      cur = tok_q[1];
    end else begin
      cur = tok_q[2];
    end
    vld_after = (pop_i && (|vld_q)) ? rem : vld_q;
    load      = grp_avail_i && (vld_after == 3'b000);
    vld_d     = load ? grp_i.vld : vld_after;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q <= grp_i.tok;
    end
  end

  assign grp_take_o          = load;
  assign empty_o             = ~(|vld_q);
  assign item_o.token_kind   = cur.kind;
  assign item_o.token_start  = cur.start;
  assign item_o.token_length = cur.length;
  assign item_o.number_value = cur.value;
  assign item_o.run_last     = (rem == 3'b000);

endmodule
`default_nettype wire

[hdl/expression_char_tokenizer.sv]
// Top level of the expression character tokenizer.
// Instantiates ect_front, ect_fifo and ect_back; depends on ect_pkg.
//
//   channel  | handshake         | beat
//   ---------+-------------------+---------------------------------------
//   input    | push / full       | in_item_i: char_in, line_end
//   result   | pop / empty       | out_item_o: kind, start, length,
//            |                   |   number_value, run_last
//
// One byte per cycle is taken while full is low; the front end updates the
// run state and the decimal accumulator as each byte is taken. Each byte
// yields zero to three tokens, delivered one per cycle by the back end, so
// sustained input rate is limited by the token count per byte and by pop.
// A 4-entry group queue decouples the two ends; full rises when it fills.
// Reset clears run state, line position and queue; no clearing sweep.
`default_nettype none
module expression_char_tokenizer #(
  parameter int MAX_LINE_LEN = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire ect_pkg::in_item_t  in_item_i,
  output logic                    empty,
  input  wire logic               pop,
  output ect_pkg::out_item_t      out_item_o
);
  import ect_pkg::*;

  tok_group_t grp_wr, grp_rd;
  logic       grp_wr_vld, grp_take, fifo_full, fifo_ne, accept;

  assign accept = push && !fifo_full;
  assign full   = fifo_full;

  ect_front #(
    .MAX_LINE_LEN(MAX_LINE_LEN)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .grp_o    (grp_wr),
    .grp_vld_o(grp_wr_vld)
  );

  ect_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (grp_wr_vld),
    .wr_data_i  (grp_wr),
    .rd_i       (grp_take),
    .rd_data_o  (grp_rd),
    .full_o     (fifo_full),
    .not_empty_o(fifo_ne)
  );

  ect_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .grp_i      (grp_rd),
    .grp_avail_i(fifo_ne),
    .grp_take_o (grp_take),
    .pop_i      (pop),
    .empty_o    (empty),
    .item_o     (out_item_o)
  );

endmodule
`default_nettype wire

[hdl/ect_checker.sv]
// Port-level checks for expression_char_tokenizer, bound to the top level.
// Depends on ect_pkg.
`default_nettype none
module ect_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire ect_pkg::out_item_t out_item_o
);
  import ect_pkg::*;

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> empty && !full)
    else $error("outputs not idle in reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("waiting beat changed");

  a_group_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && !out_item_o.run_last |=> !empty)
    else $error("token group cut short");

  a_eol_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.token_kind == TK_EOL |->
      out_item_o.run_last && out_item_o.token_length == 11'd0 &&
      out_item_o.number_value == 31'd0)
    else $error("bad end of line token");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.token_kind != TK_NUMBER |-> out_item_o.number_value == 31'd0)
    else $error("value on non-number token");

endmodule

bind expression_char_tokenizer ect_checker u_ect_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_item_o(out_item_o)
);
`default_nettype wire

[verif/tb_expression_char_tokenizer.sv]
`timescale 1ns / 100ps
// Self-checking testbench for expression_char_tokenizer: directed and random lines,
// predicted tokens checked beat by beat. Depends on ect_pkg and the hdl/ sources.
module tb_expression_char_tokenizer;
  import ect_pkg::*;

  localparam int LineMax = 1024;

  class token_scoreboard;
    out_item_t   pending_tokens[$];
    int unsigned fail_count;
    run_kind_e   run_kind;
    logic [10:0] run_start;
    logic [10:0] run_length;
    logic [30:0] acc_value;
    logic        acc_ovf;
    logic [10:0] line_pos;

    function new();
      fail_count = 0;
      line_pos   = '0;
      clear_run();
    endfunction

    function void clear_run();
      run_kind   = RUN_NONE;
      run_start  = '0;
      run_length = '0;
      acc_value  = '0;
      acc_ovf    = 1'b0;
    endfunction

    function logic [10:0] bump(logic [10:0] v);
      return (v >= 11'(LineMax)) ? 11'(LineMax) : v + 11'd1;
    endfunction

    function void emit(tok_kind_e k, logic [10:0] s, logic [10:0] l, logic [30:0] v);
      out_item_t t;
      t.token_kind   = k;
      t.token_start  = s;
      t.token_length = l;
      t.number_value = v;
      t.run_last     = 1'b0;
      pending_tokens.push_back(t);
    endfunction

    function void close_run();
      if (run_kind == RUN_DIGIT) begin
        if (acc_ovf) emit(TK_BAD, run_start, run_length, '0);
        else emit(TK_NUMBER, run_start, run_length, acc_value);
      end else if (run_kind == RUN_BLANK) begin
        emit(TK_SPACE, run_start, run_length, '0);
      end
      clear_run();
    endfunction

    function void note_byte(in_item_t item);
      logic [7:0]      ch;
      run_kind_e       cls;
      tok_kind_e       k;
      int              first;
      longint unsigned nv;
      out_item_t       tail;
      ch    = item.char_in;
      first = pending_tokens.size();
      if (ch >= ChZero && ch <= ChNine) cls = RUN_DIGIT;
      else if (ch == ChSpace || ch == ChTab) cls = RUN_BLANK;
      else cls = RUN_NONE;
      if (cls == RUN_NONE || cls != run_kind) close_run();
      if (cls != RUN_NONE) begin
        if (run_kind == RUN_NONE) begin
          run_kind  = cls;
          run_start = line_pos;
        end
        run_length = bump(run_length);
        if (cls == RUN_DIGIT && !acc_ovf) begin
          nv = acc_value;
          nv = nv * 10 + (ch - ChZero);
          if (nv > 64'd2147483647) begin
            acc_ovf   = 1'b1;
            acc_value = '0;
          end else begin
            acc_value = nv[30:0];
          end
        end
      end else begin
        case (ch)
          ChPlus:  k = TK_PLUS;
          ChMinus: k = TK_MINUS;
          ChStar:  k = TK_STAR;
          ChSlash: k = TK_SLASH;
          ChOpen:  k = TK_OPEN;
          ChClose: k = TK_CLOSE;
          default: k = TK_BAD;
        endcase
        emit(k, line_pos, 11'd1, '0);
      end
      line_pos = bump(line_pos);
      if (item.line_end) begin
        close_run();
        emit(TK_EOL, line_pos, '0, '0);
        line_pos = '0;
      end
      if (pending_tokens.size() > first) begin
        tail = pending_tokens.pop_back();
        tail.run_last = 1'b1;
        pending_tokens.push_back(tail);
      end
    endfunction

    function void flag(string msg);
      fail_count++;
      if (fail_count <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_token(out_item_t got);
      out_item_t want;
      if (pending_tokens.size() == 0) begin
        flag($sformatf("unexpected token kind=%0d start=%0d len=%0d val=%0d last=%0b",
                       got.token_kind, got.token_start, got.token_length,
                       got.number_value, got.run_last));
        return;
      end
      want = pending_tokens.pop_front();
      if (got.token_kind !== want.token_kind || got.token_start !== want.token_start ||
          got.token_length !== want.token_length ||
          got.number_value !== want.number_value || got.run_last !== want.run_last)
        flag({$sformatf("token exp kind=%0d start=%0d len=%0d val=%0d last=%0b",
                        want.token_kind, want.token_start, want.token_length,
                        want.number_value, want.run_last),
              $sformatf(", got kind=%0d start=%0d len=%0d val=%0d last=%0b",
                        got.token_kind, got.token_start, got.token_length,
                        got.number_value, got.run_last)});
    endfunction
  endclass

  logic      clk_i    = 1'b0;
  logic      rst_ni;
  logic      push     = 1'b0;
  logic      full;
  in_item_t  in_item  = '0;
  logic      empty;
  logic      pop      = 1'b0;
  out_item_t out_item;

  token_scoreboard sb = new();
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  bit              hold_req       = 1'b0;

  expression_char_tokenizer #(
    .MAX_LINE_LEN(LineMax)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // everything is stable mid-cycle; a beat seen here moves at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) sb.note_byte(in_item);
      if (pop && !empty) sb.check_token(out_item);
    end
  end

  initial begin : rx
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = 200;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] ch, input logic eol);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= {ch, eol};
    do @(negedge clk_i); while (full);
    @(posedge clk_i);
  endtask

  task automatic send_line(input logic [7:0] chars[$]);
    foreach (chars[i]) send_byte(chars[i], i == chars.size() - 1);
  endtask

  task automatic wait_drained();
    while (sb.pending_tokens.size() != 0) @(posedge clk_i);
  endtask

  function automatic void add_text(ref logic [7:0] chars[$], input string s);
    for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return ChZero + 8'($urandom_range(9));
    if (r < 55) return ChSpace;
    if (r < 62) return ChTab;
    if (r < 85) begin
      case ($urandom_range(5))
        0:       return ChPlus;
        1:       return ChMinus;
        2:       return ChStar;
        3:       return ChSlash;
        4:       return ChOpen;
        default: return ChClose;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random_line(inout int unsigned count);
    logic [7:0]  chars[$];
    int unsigned len;
    int unsigned r;
    r   = $urandom_range(99);
    len = $urandom_range(1, 16);
    if (r < 8) begin
      for (int i = 0; i < len; i++) chars.push_back(8'($urandom_range(255)));
    end else begin
      for (int i = 0; i < len; i++) chars.push_back(pick_byte());
      if (r < 14) add_text(chars, ($urandom_range(1)) ? "2147483647" : "2147483648");
      else if (r < 18)
        for (int i = 0; i < $urandom_range(11, 20); i++)
          chars.push_back(ChZero + 8'($urandom_range(9)));
      if ($urandom_range(1)) chars.push_back(pick_byte());
    end
    count += chars.size();
    send_line(chars);
  endtask

  initial begin
    logic [7:0]  chars[$];
    int unsigned phase_bytes;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every operator, both blanks, byte extremes, line end on a bad byte
    add_text(chars, "(12 \t-3)*/+");
    chars.push_back(8'h00);
    chars.push_back(8'hFF);
    chars.push_back(8'h0D);
    send_line(chars);
    chars.delete();
    // too large for 31 bits, flushed by line end
    add_text(chars, "9999999999");
    send_line(chars);
    push <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      if (ph == 0) hold_req = 1'b1;
      phase_bytes = 0;
      while (phase_bytes < 100) send_random_line(phase_bytes);
      push <= 1'b0;
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (sb.pending_tokens.size() != 0)
      sb.flag($sformatf("%0d tokens never arrived", sb.pending_tokens.size()));
    if (sb.fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
